// ----- src/psq_pkg.sv -----
// shared constants and codes of the pending interrupt slot queue
package psq_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int WORD_W         = 32;

  localparam int INFO_VALID_BIT = 31;
  localparam int INFO_ERRC_BIT  = 11;
  localparam int INFO_TYPE_LO   = 8;
  localparam int INFO_TYPE_HI   = 10;

  localparam logic [2:0] INFO_TYPE_EXT = 3'd0;

  localparam logic CMD_EXT_EXIT = 1'b0;
  localparam logic CMD_WINDOW   = 1'b1;

  localparam logic [2:0] ACT_INJECT  = 3'd0;
  localparam logic [2:0] ACT_QUEUED  = 3'd1;
  localparam logic [2:0] ACT_DROPPED = 3'd2;
  localparam logic [2:0] ACT_NOT_EXT = 3'd3;
  localparam logic [2:0] ACT_NONE    = 3'd4;

  localparam logic [1:0] WIN_KEEP    = 2'd0;
  localparam logic [1:0] WIN_ENABLE  = 2'd1;
  localparam logic [1:0] WIN_DISABLE = 2'd2;

endpackage

// ----- src/psq_ifs.sv -----
// channel interfaces of the pending interrupt slot queue
interface psq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [psq_pkg::WORD_W-1:0]  interrupt_info;
  logic                        guest_if_flag;
  logic                        blocked_by_mov_ss;

  modport source (output valid, cmd, interrupt_info, guest_if_flag, blocked_by_mov_ss,
                  input ready);
  modport sink (input valid, cmd, interrupt_info, guest_if_flag, blocked_by_mov_ss,
                output ready);
endinterface

interface psq_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  action;
  logic [psq_pkg::WORD_W-1:0]  inject_word;
  logic [1:0]                  window_change;
  logic                        error_code_follows;

  modport source (output valid, action, inject_word, window_change, error_code_follows,
                  input ready);
  modport sink (input valid, action, inject_word, window_change, error_code_follows,
                output ready);
endinterface

interface psq_cfg_if;
  logic valid;
  logic ready;
  logic hold_interrupts;

  modport source (output valid, hold_interrupts, input ready);
  modport sink (input valid, hold_interrupts, output ready);
endinterface

// ----- src/psq_ram.sv -----
// generic single-port-write, registered-read ram
module psq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- src/psq_first_set.sv -----
// lowest set bit finder over the slot occupancy map
module psq_first_set #(
  parameter int N = 32,
  localparam int IDX_W = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]     vec,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  logic [N-1:0] lowest;

  // isolate the lowest set bit, then encode it
  assign lowest = vec & (~vec + N'(1));
  assign found  = |vec;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule

// ----- src/pending_interrupt_slot_queue_top.sv -----
// top level of the pending interrupt slot queue
//
// channels: in_ch takes one event item (cmd, interrupt_info, guest_if_flag,
// blocked_by_mov_ss), out_ch returns exactly one result item per event
// (action, inject_word, window_change, error_code_follows), cfg_ch writes
// the hold_interrupts register and is always ready.
// the slot words live in a ram with registered read; a flip-flop
// occupancy map marks which slots hold a nonzero word and lowest-bit
// finders over that map and its inverse pick the slot for pop and store.
// the result is registered from the search step for an external interrupt
// event or a window event on an empty table, and from the read step, after
// the ram read, for a window event that pops a slot.
// in_ch takes a new event only in the idle state, so no item is accepted
// until the previous one has passed the search step and any read step.
// reset clears the occupancy map, so every slot reads as empty at once,
// and clears hold_interrupts; no clearing pass is needed.
// a stalled receiver holds the result in the output register; the next item
// may still be accepted and waits in the search or read step until the
// output register frees.
module pending_interrupt_slot_queue_top #(
  parameter int SLOT_COUNT = psq_pkg::SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  psq_cfg_if.sink   cfg_ch,
  psq_in_if.sink    in_ch,
  psq_out_if.source out_ch
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ
  } state_t;

  state_t state_r, state_nxt;

  logic                        hold_r;
  logic [SLOT_COUNT-1:0]       occ_r, occ_nxt;

  logic                        cmd_r;
  logic [psq_pkg::WORD_W-1:0]  info_r;
  logic                        if_r;
  logic                        movss_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_action_r, out_action_nxt;
  logic [psq_pkg::WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [1:0]                  out_win_r, out_win_nxt;

  logic                        occ_found, empty_found;
  logic [IDX_W-1:0]            occ_idx, empty_idx;

  logic                        ram_we, ram_re;
  logic [psq_pkg::WORD_W-1:0]  ram_rdata;

  logic                        in_acc;
  logic                        out_free;
  logic                        is_ext;
  logic                        interruptible;

  psq_first_set #(.N(SLOT_COUNT)) u_find_occ (
    .vec   (occ_r),
    .found (occ_found),
    .idx   (occ_idx)
  );

  psq_first_set #(.N(SLOT_COUNT)) u_find_empty (
    .vec   (~occ_r),
    .found (empty_found),
    .idx   (empty_idx)
  );

  psq_ram #(.WIDTH(psq_pkg::WORD_W), .DEPTH(SLOT_COUNT)) u_slots (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (empty_idx),
    .wdata   (info_r),
    .re      (ram_re),
    .raddr   (occ_idx),
    .rdata_r (ram_rdata)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign is_ext = info_r[psq_pkg::INFO_VALID_BIT] &&
                  (info_r[psq_pkg::INFO_TYPE_HI:psq_pkg::INFO_TYPE_LO] ==
                   psq_pkg::INFO_TYPE_EXT);
  assign interruptible = if_r && !movss_r;

  always_comb begin
    logic do_store;
    logic [1:0] store_win;
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_action_nxt = out_action_r;
    out_word_nxt   = out_word_r;
    out_win_nxt    = out_win_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    do_store       = 1'b0;
    store_win      = psq_pkg::WIN_KEEP;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (cmd_r == psq_pkg::CMD_WINDOW) begin
          if (occ_found) begin
            // pop: read the slot and free it, result follows from the ram
            ram_re                = 1'b1;
            occ_nxt[occ_idx]      = 1'b0;
            state_nxt             = S_READ;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_action_nxt = psq_pkg::ACT_NONE;
            out_word_nxt   = '0;
            out_win_nxt    = psq_pkg::WIN_DISABLE;
            state_nxt      = S_IDLE;
          end
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_win_nxt   = psq_pkg::WIN_KEEP;
          state_nxt     = S_IDLE;
          if (hold_r) begin
            do_store = 1'b1;
          end else if (is_ext) begin
            if (interruptible) begin
              out_action_nxt = psq_pkg::ACT_INJECT;
              out_word_nxt   = info_r;
            end else begin
              do_store  = 1'b1;
              store_win = psq_pkg::WIN_ENABLE;
            end
          end else begin
            out_action_nxt = psq_pkg::ACT_NOT_EXT;
          end
          if (do_store) begin
            out_win_nxt = store_win;
            if (empty_found) begin
              out_action_nxt = psq_pkg::ACT_QUEUED;
              // a zero word leaves the slot empty
              if (info_r != '0) begin
                ram_we             = 1'b1;
                occ_nxt[empty_idx] = 1'b1;
              end
            end else begin
              out_action_nxt = psq_pkg::ACT_DROPPED;
            end
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = psq_pkg::ACT_INJECT;
          out_word_nxt   = ram_rdata;
          out_win_nxt    = psq_pkg::WIN_KEEP;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_r      <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        hold_r <= cfg_ch.hold_interrupts;
      end
    end
    if (in_acc) begin
      cmd_r   <= in_ch.cmd;
      info_r  <= in_ch.interrupt_info;
      if_r    <= in_ch.guest_if_flag;
      movss_r <= in_ch.blocked_by_mov_ss;
    end
    out_action_r <= out_action_nxt;
    out_word_r   <= out_word_nxt;
    out_win_r    <= out_win_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.action             = out_action_r;
  assign out_ch.inject_word        = out_word_r;
  assign out_ch.window_change      = out_win_r;
  assign out_ch.error_code_follows = out_word_r[psq_pkg::INFO_ERRC_BIT];

  // at most one slot changes occupancy per cycle
  a_one_slot_change: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_r ^ $past(occ_r)) <= 1)
    else $error("more than one slot changed occupancy in a cycle");

  // a popped slot is free in the following cycle
  a_pop_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> !occ_r[$past(occ_idx)])
    else $error("popped slot still marked occupied");

  // only an inject result carries a word
  a_word_only_on_inject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != psq_pkg::ACT_INJECT) |->
      (out_word_r == '0 && !out_ch.error_code_follows))
    else $error("non-inject result carries a word");

  // a pop read is only issued for an occupied slot
  a_pop_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (occ_found && state_r == S_SEARCH))
    else $error("ram read without an occupied slot");

endmodule
